[hdl/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg - shared types and constants of the packet deframer
// Beat layouts, event codes, register indexes, reset values and the
// byte-wide CRC16 (reflected 0xA001) update.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

  // Frame layout constants.
  localparam logic [7:0]  STX_BYTE      = 8'h02;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int unsigned HEADER_BYTES  = 5;
  localparam int unsigned BUFFER_BYTES  = 256;

  // Byte position reaches 256 at most; the CRC end reaches 5 + 255.
  localparam int unsigned POS_W = 9;

  // Register reset values.
  localparam logic [7:0]  HB_TYPE_RST     = 8'd1;
  localparam logic [7:0]  HB_ACK_TYPE_RST = 8'd2;
  localparam logic [15:0] TIMEOUT_RST     = 16'd15000;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HB_TYPE     = 2'd0,
    REG_HB_ACK_TYPE = 2'd1,
    REG_TIMEOUT     = 2'd2
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_GOOD      = 3'd1,
    EV_CRC_ERR   = 3'd2,
    EV_OVERFLOW  = 3'd3,
    EV_LINK_LOST = 3'd4
  } event_e;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic       is_tick;
    logic       is_stx;
    logic [7:0] data;
  } item_t;

  // One result beat.
  typedef struct packed {
    event_e     ev;
    logic [7:0] ftype;
    logic [7:0] flen;
    logic       ack;
    logic       link_up;
  } result_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Configuration write as seen by the back end.
  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
  } cfg_wr_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/cpd_front.sv]
// ----------------------------------------------------------------------------
// cpd_front - input acceptance, classification and item queue
// Accepts beats, tags ticks and start bytes, and holds them in a
// two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           opcode_i,
  input  wire logic [7:0]     rx_byte_i,
  output cpd_pkg::queue_head_t head_o,
  input  wire logic           pop_i
);

  localparam int unsigned QDEPTH = 2;

  cpd_pkg::item_t mem_q [QDEPTH];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;
  cpd_pkg::item_t item_in;

  assign in_stall_o = (count_q == 2'(QDEPTH));
  assign push       = in_valid_i & ~in_stall_o;
  assign pop        = pop_i & (count_q != 2'd0);

  always_comb begin
    item_in.is_tick = (opcode_i == cpd_pkg::OP_TICK);
    item_in.is_stx  = (rx_byte_i == cpd_pkg::STX_BYTE);
    item_in.data    = rx_byte_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[hdl/cpd_back.sv]
// ----------------------------------------------------------------------------
// cpd_back - frame parser, CRC, link supervisor and result register
// Drains one queued item per cycle unless the output stalls, updates the
// frame and link state and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cpd_pkg::queue_head_t head_i,
  output logic                   pop_o,
  input  wire cpd_pkg::cfg_wr_t  cfg_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cpd_pkg::result_t       result_o
);

  // Configuration registers.
  logic [7:0]  hb_type_q;
  logic [7:0]  hb_ack_type_q;
  logic [15:0] timeout_q;

  // Parser and link state.
  logic [cpd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        conn_q, conn_d;
  logic [15:0] idle_q, idle_d;

  logic                      out_valid_q;
  cpd_pkg::result_t          out_q, res;
  logic [cpd_pkg::POS_W-1:0] crc_end;
  logic [15:0]               idle_inc;
  logic [15:0]               rx_crc;
  cpd_pkg::item_t            it;

  assign it    = head_i.item;
  assign pop_o = head_i.valid & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_type_q     <= cpd_pkg::HB_TYPE_RST;
      hb_ack_type_q <= cpd_pkg::HB_ACK_TYPE_RST;
      timeout_q     <= cpd_pkg::TIMEOUT_RST;
    end else if (cfg_i.wr) begin
      case (cfg_i.idx)
        cpd_pkg::REG_HB_TYPE:     hb_type_q     <= cfg_i.data[7:0];
        cpd_pkg::REG_HB_ACK_TYPE: hb_ack_type_q <= cfg_i.data[7:0];
        cpd_pkg::REG_TIMEOUT:     timeout_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    type_d   = type_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    conn_d   = conn_q;
    idle_d   = idle_q;
    res      = '0;
    res.ev   = cpd_pkg::EV_NONE;
    idle_inc = (idle_q != cpd_pkg::IDLE_MAX) ? idle_q + 16'd1 : idle_q;
    crc_end  = '0;
    rx_crc   = {it.data, crc_lo_q};

    if (it.is_tick) begin
      idle_d = idle_inc;
      if (conn_q && (idle_inc > timeout_q)) begin
        conn_d = 1'b0;
        res.ev = cpd_pkg::EV_LINK_LOST;
      end
    end else if ((pos_q == '0) && !it.is_stx) begin
      // Hunting for a start byte: drop it.
    end else if (32'(pos_q) >= 32'(cpd_pkg::BUFFER_BYTES)) begin
      res.ev    = cpd_pkg::EV_OVERFLOW;
      res.ftype = type_q;
      res.flen  = len_q;
      pos_d     = '0;
      crc_d     = cpd_pkg::CRC_INIT;
    end else begin
      if (pos_q == cpd_pkg::POS_W'(1)) begin
        type_d = it.data;
      end
      if (pos_q == cpd_pkg::POS_W'(2)) begin
        len_d = it.data;
      end
      crc_end = cpd_pkg::POS_W'(len_d) + cpd_pkg::POS_W'(cpd_pkg::HEADER_BYTES);
      if (pos_q < crc_end) begin
        crc_d = cpd_pkg::crc16_byte(crc_q, it.data);
        pos_d = pos_q + 1'b1;
      end else if (pos_q == crc_end) begin
        crc_lo_d = it.data;
        pos_d    = pos_q + 1'b1;
      end else begin
        res.ftype = type_d;
        res.flen  = len_d;
        if (rx_crc == crc_q) begin
          res.ev = cpd_pkg::EV_GOOD;
          if ((type_d == hb_type_q) || (type_d == hb_ack_type_q)) begin
            conn_d  = 1'b1;
            idle_d  = '0;
            res.ack = (type_d == hb_type_q);
          end
        end else begin
          res.ev = cpd_pkg::EV_CRC_ERR;
        end
        pos_d = '0;
        crc_d = cpd_pkg::CRC_INIT;
      end
    end
    res.link_up = conn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      type_q      <= '0;
      crc_q       <= cpd_pkg::CRC_INIT;
      crc_lo_q    <= '0;
      conn_q      <= 1'b0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_q    <= pos_d;
        len_q    <= len_d;
        type_q   <= type_d;
        crc_q    <= crc_d;
        crc_lo_q <= crc_lo_d;
        conn_q   <= conn_d;
        idle_q   <= idle_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

[hdl/crc16_packet_deframer_with_link_timeout.sv]
// ----------------------------------------------------------------------------
// crc16_packet_deframer_with_link_timeout - STX/length/CRC16 frame receiver
// Parses STX framed packets from a byte stream, checks their Modbus CRC16
// on the fly and supervises the link with heartbeats and millisecond ticks.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Beat contents
//   -------   ---------  ----------------------  ------------------------------
//   in        sink       in_valid_i / in_stall_o  opcode_i, rx_byte_i
//   out       source     out_valid_o / out_stall_i event_res_o, frame_type_o,
//                                                 frame_length_o, send_ack_o,
//                                                 link_up_o
//   cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One input beat is taken per cycle while in_stall_o is low, and each beat
// produces exactly one result beat: it is written into the two-entry item
// queue, then passes through the parser into the result register.
// The sustained rate is one beat per cycle while the output does not stall;
// the parser step (byte-wide CRC update plus compare) sets it.
// Reset clears the frame state, the link flag, the idle counter and restores
// the register defaults; no clearing pass is needed.
// A stalled output holds the result register; the parser then stops draining
// and the queue absorbs up to two more beats before in_stall_o rises.
`default_nettype none

module crc16_packet_deframer_with_link_timeout (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Item input.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [7:0]                    rx_byte_i,
  // Result output.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         event_res_o,
  output logic [7:0]                         frame_type_o,
  output logic [7:0]                         frame_length_o,
  output logic                               send_ack_o,
  output logic                               link_up_o,
  // Register writes.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);

  cpd_pkg::queue_head_t head;
  logic                 pop;
  cpd_pkg::cfg_wr_t     cfg_wr;
  cpd_pkg::result_t     result;

  // Registers are only to be written while the block is quiet; the block itself
  // leaves this unchecked. cfg_ready_o is tied high, so writes are always taken at once.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_wr.wr   = cfg_valid_i & cfg_ready_o;
    cfg_wr.idx  = cfg_index_i;
    cfg_wr.data = cfg_data_i;
  end

  // The front end tags each beat and queues it.
  cpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .rx_byte_i  (rx_byte_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // The back end runs the frame parser and the link supervisor.
  cpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_i       (cfg_wr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign event_res_o    = result.ev;
  assign frame_type_o   = result.ftype;
  assign frame_length_o = result.flen;
  assign send_ack_o     = result.ack;
  assign link_up_o      = result.link_up;

endmodule

`default_nettype wire

[tb/sv/tb_deframer_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deframer_scoreboard_pkg - expected-result tracking for the deframer bench
// Holds a beat-accurate model of the frame parser and link supervisor, queues
// the result it predicts for every accepted input beat and compares the
// block's result beats against that queue in order.
// ----------------------------------------------------------------------------

package tb_deframer_scoreboard_pkg;
  import cpd_pkg::*;

  // One byte of the reflected Modbus CRC16.
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  class deframer_scoreboard;
    logic [7:0]  hb_type;
    logic [7:0]  hb_ack_type;
    logic [15:0] timeout_ticks;

    int unsigned frame_pos;
    logic [7:0]  held_len;
    logic [7:0]  held_type;
    logic [7:0]  crc_lo;
    logic [15:0] crc_acc;
    logic [15:0] idle_ticks;
    logic        link_up;

    result_t     awaited[$];
    int unsigned mismatches;

    function new();
      hb_type       = HB_TYPE_RST;
      hb_ack_type   = HB_ACK_TYPE_RST;
      timeout_ticks = TIMEOUT_RST;
      frame_pos     = 0;
      held_len      = '0;
      held_type     = '0;
      crc_lo        = '0;
      crc_acc       = CRC_INIT;
      idle_ticks    = '0;
      link_up       = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
        REG_HB_TYPE:     hb_type       = d[7:0];
        REG_HB_ACK_TYPE: hb_ack_type   = d[7:0];
        REG_TIMEOUT:     timeout_ticks = d;
        default: ;
      endcase
    endfunction

    function int unsigned pending_count();
      return awaited.size();
    endfunction

    // Advance the parser by one accepted beat and queue what it must produce.
    function void note_beat(opcode_e op, logic [7:0] b);
      result_t r;
      r = '0;
      if (op == OP_TICK) begin
        if (idle_ticks != IDLE_MAX) idle_ticks++;
        if (link_up && idle_ticks > timeout_ticks) begin
          link_up = 1'b0;
          r.ev    = EV_LINK_LOST;
        end
      end else if (frame_pos == 0 && b != STX_BYTE) begin
        // Hunting for a start byte: everything else falls on the floor.
      end else if (frame_pos >= BUFFER_BYTES) begin
        r.ev      = EV_OVERFLOW;
        r.ftype   = held_type;
        r.flen    = held_len;
        frame_pos = 0;
        crc_acc   = CRC_INIT;
      end else begin
        if (frame_pos == 1) held_type = b;
        else if (frame_pos == 2) held_len = b;
        if (frame_pos < HEADER_BYTES + held_len || frame_pos < HEADER_BYTES) begin
          crc_acc = crc16_modbus_step(crc_acc, b);
          frame_pos++;
        end else if (frame_pos == HEADER_BYTES + held_len) begin
          crc_lo = b;
          frame_pos++;
        end else begin
          r.ftype = held_type;
          r.flen  = held_len;
          if ({b, crc_lo} == crc_acc) begin
            r.ev = EV_GOOD;
            if (held_type == hb_type || held_type == hb_ack_type) begin
              link_up    = 1'b1;
              idle_ticks = '0;
              r.ack      = (held_type == hb_type);
            end
          end else begin
            r.ev = EV_CRC_ERR;
          end
          frame_pos = 0;
          crc_acc   = CRC_INIT;
        end
      end
      r.link_up = link_up;
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_beat(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, event %0d", got.ev));
        return;
      end
      want = awaited.pop_front();
      if (got.ev !== want.ev)
        report_mismatch($sformatf("event %0d, wanted %0d", got.ev, want.ev));
      if (got.ftype !== want.ftype)
        report_mismatch($sformatf("frame type %02h, wanted %02h", got.ftype, want.ftype));
      if (got.flen !== want.flen)
        report_mismatch($sformatf("frame length %0d, wanted %0d", got.flen, want.flen));
      if (got.ack !== want.ack)
        report_mismatch($sformatf("send_ack %b, wanted %b", got.ack, want.ack));
      if (got.link_up !== want.link_up)
        report_mismatch($sformatf("link_up %b, wanted %b", got.link_up, want.link_up));
    endtask
  endclass

endpackage

[tb/sv/tb_crc16_packet_deframer_with_link_timeout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_packet_deframer_with_link_timeout - self-checking deframer bench
// Feeds framed packets, line noise and millisecond ticks into the deframer
// under several register settings, with random gaps and back-pressure on
// both channels, and checks every result beat against a predicted stream.
// ----------------------------------------------------------------------------

module tb_crc16_packet_deframer_with_link_timeout;
  import cpd_pkg::*;
  import tb_deframer_scoreboard_pkg::*;

  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned PHASE_ITEMS  = 120;
  // Index two bits wide can address a fourth register that does not exist.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 opcode_i       = 1'b0;
  logic [7:0]           rx_byte_i      = 8'h00;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [2:0]           event_res_o;
  logic [7:0]           frame_type_o;
  logic [7:0]           frame_length_o;
  logic                 send_ack_o;
  logic                 link_up_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [15:0]          cfg_data_i     = '0;

  // When set, neither side inserts gaps; used for the timeout check at the end.
  bit quiet    = 1'b0;
  // When set, ticks are sprinkled between the bytes of a frame.
  bit tick_mix = 1'b0;

  deframer_scoreboard sb = new();

  crc16_packet_deframer_with_link_timeout uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .frame_type_o  (frame_type_o),
    .frame_length_o(frame_length_o),
    .send_ack_o    (send_ack_o),
    .link_up_o     (link_up_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin : clock_gen
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Offer one beat and return at the edge that accepts it. Valid is only
  // lowered when a gap is drawn, so back-to-back beats keep it high and it
  // never gets two updates in the same time step.
  task automatic send_beat(opcode_e op, logic [7:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_beat(op, b);
  endtask

  // Build one frame with a correct or damaged CRC and send it, possibly cut
  // short. Returns the number of frame bytes actually sent.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen, input bit crc_ok,
                            input bit truncate, output int unsigned sent);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    int unsigned cut;
    frame_bytes = {STX_BYTE, ftype, flen, 8'($urandom), 8'($urandom)};
    repeat (flen) frame_bytes.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = crc16_modbus_step(crc, frame_bytes[i]);
    if (!crc_ok) crc ^= 16'($urandom_range(1, 16'hFFFF));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    if (truncate) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      frame_bytes = frame_bytes[0:cut-1];
    end
    sent = frame_bytes.size();
    foreach (frame_bytes[i]) begin
      if (tick_mix && $urandom_range(0, 9) == 0) send_beat(OP_TICK, 8'($urandom));
      send_beat(OP_BYTE, frame_bytes[i]);
    end
  endtask

  // Drop valid and wait until every predicted result has come back, so the
  // block is idle for register writes.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Valid stays high across a batch of writes; the caller lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, d);
  endtask

  // The 8-bit registers get random upper data bits, which must be ignored.
  task automatic apply_settings(logic [7:0] hb, logic [7:0] ack, logic [15:0] tmo);
    settle_block();
    write_reg(REG_HB_TYPE, {8'($urandom), hb});
    write_reg(REG_HB_ACK_TYPE, {8'($urandom), ack});
    write_reg(REG_TIMEOUT, tmo);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, a share of heartbeats so
  // the link comes up, ticks so it times out again, and some noise, damaged
  // CRCs and cut-off frames. One very long frame can be placed mid-phase to
  // reach the buffer edge.
  task automatic run_random_phase(int unsigned target, int unsigned long_len);
    int unsigned phase_items;
    int unsigned pick;
    int unsigned sent;
    bit          long_done;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    phase_items = 0;
    long_done   = (long_len == 0);
    tick_mix    = 1'b1;
    while (phase_items < target) begin
      pick = $urandom_range(0, 99);
      if (!long_done && phase_items >= target / 2) begin
        send_frame(sb.hb_type, 8'(long_len), 1'b1, 1'b0, sent);
        phase_items += sent;
        long_done = 1'b1;
      end else if (pick < 15) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(OP_TICK, 8'($urandom));
          phase_items++;
        end
      end else if (pick < 25) begin
        // Line noise between frames; mostly dropped, so it is not counted.
        repeat ($urandom_range(1, 3)) send_beat(OP_BYTE, 8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      ftype = sb.hb_type;
        else if (pick < 60) ftype = sb.hb_ack_type;
        else                ftype = 8'($urandom);
        flen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                           : 8'($urandom_range(0, 8));
        send_frame(ftype, flen, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 8, sent);
        phase_items += sent;
      end
    end
    tick_mix = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values: byte extremes while
    // hunting, a tick while the link is down, a heartbeat that brings the
    // link up and asks for an ack, an ack-type frame with one payload byte,
    // and a frame with a damaged CRC.
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_TICK, 8'hFF);
    send_frame(HB_TYPE_RST, 8'd0, 1'b1, 1'b0, sent);
    send_frame(HB_ACK_TYPE_RST, 8'd1, 1'b1, 1'b0, sent);
    send_frame(HB_TYPE_RST, 8'd2, 1'b0, 1'b0, sent);
    send_beat(OP_TICK, 8'h00);

    // Extreme codes and a timeout of 1; the longest frame that still
    // fits in the buffer.
    apply_settings(8'h00, 8'hFF, 16'd1);
    run_random_phase(PHASE_ITEMS, 249);

    // Both type registers hold the same code: such a frame counts as a
    // heartbeat. The long frame here overflows on its last byte.
    apply_settings(8'h5A, 8'h5A, 16'd4);
    run_random_phase(PHASE_ITEMS, 250);

    // Random codes and timeout, longest possible length (overflow).
    apply_settings(8'($urandom), 8'($urandom), 16'($urandom_range(2, 30)));
    run_random_phase(PHASE_ITEMS, 255);

    // Zero timeout: the first tick after any heartbeat drops the link.
    apply_settings(8'hFF, 8'h00, 16'd0);
    run_random_phase(PHASE_ITEMS, 0);

    // Defaults back, a write to the unused index that must change nothing,
    // and the largest regular timeout.
    apply_settings(HB_TYPE_RST, HB_ACK_TYPE_RST, 16'hFFFE);
    @(posedge clk_i);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid_i <= 1'b0;
    run_random_phase(PHASE_ITEMS, 0);

    // A lowered timeout takes effect on the very next tick.
    apply_settings(sb.hb_type, sb.hb_ack_type, 16'd100);
    quiet = 1'b1;
    send_frame(sb.hb_type, 8'd0, 1'b1, 1'b0, sent);
    repeat (20) send_beat(OP_TICK, 8'($urandom));
    settle_block();
    write_reg(REG_TIMEOUT, 16'd5);
    cfg_valid_i <= 1'b0;
    send_beat(OP_TICK, 8'($urandom));
    quiet = 1'b0;

    settle_block();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: a random stall before each beat, and twice a long hold so
  // the internal queue fills and the input channel has to stall.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    result_t     got;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (taken == 150 || taken == 400) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.ev      = event_e'(event_res_o);
      got.ftype   = frame_type_o;
      got.flen    = frame_length_o;
      got.ack     = send_ack_o;
      got.link_up = link_up_o;
      sb.check_beat(got);
      taken++;
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/cpd_pkg.sv
hdl/cpd_front.sv
hdl/cpd_back.sv
hdl/crc16_packet_deframer_with_link_timeout.sv
tb/sv/tb_deframer_scoreboard_pkg.sv
tb/sv/tb_crc16_packet_deframer_with_link_timeout.sv
